[rtl/core/class_aware_box_suppression_top_defines.svh]
// Assertion macros shared by the box suppression checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CLASS_AWARE_BOX_SUPPRESSION_TOP_DEFINES_SVH
`define CLASS_AWARE_BOX_SUPPRESSION_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CABS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box suppression check failed");

// Next-cycle implication, disabled in reset
`define CABS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box suppression check failed");

`endif

[rtl/core/cabs_pkg.sv]
// Shared constants, box entry type and controller/datapath interface structs
// for the class-aware box suppression block. No dependencies.
`default_nettype none
package cabs_pkg;
	localparam int MAX_BOXES   = 64;
	localparam int LABEL_BITS  = 7;
	localparam int IDX_W       = $clog2(MAX_BOXES);
	localparam int CNT_W       = $clog2(MAX_BOXES + 1);
	localparam int COORD_W     = 16;
	localparam int SCORE_W     = 16;
	localparam int OUT_LABEL_W = 7;
	localparam int AREA_W      = 34;
	localparam int DATA_W      = 88;
	localparam logic [15:0] THR_RESET = 16'd32768;

	typedef struct packed {
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic [SCORE_W-1:0]        score;
		logic [LABEL_BITS-1:0]     label;
		logic signed [AREA_W-1:0]  area;
	} box_t;

	typedef struct packed {
		logic             load;
		logic             clr_batch;
		logic             scan_start;
		logic             scan_rd;
		logic             sup_rd;
		logic             pick_rd;
		logic             take_pick;
		logic             emit;
		logic             emit_empty;
		logic [IDX_W-1:0] rd_idx;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
		logic             remaining;
		logic             out_full;
	} sts_t;
endpackage
`default_nettype wire

[rtl/core/cabs_dp.sv]
// Datapath: box memory, best-score scan, overlap test pipeline, suppressed
// flags and output register. Depends on cabs_pkg; driven by cabs_ctrl.
`default_nettype none
module cabs_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr_en,
	input  wire logic [15:0]                cfg_wr_data,
	input  wire logic [cabs_pkg::DATA_W-1:0] in_data,
	input  wire logic                       in_has_box,
	input  wire cabs_pkg::cmd_t             cmd,
	output cabs_pkg::sts_t                  sts,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [cabs_pkg::DATA_W-1:0]     m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);
	import cabs_pkg::*;

	box_t             mem [MAX_BOXES];
	box_t             rd_q;
	box_t             a_q;
	box_t             new_box;
	logic [15:0]      thr_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [MAX_BOXES-1:0] gone_q;
	logic [MAX_BOXES-1:0] live_mask;
	logic             wr_en;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic signed [17:0] dx, dy;
	logic signed [35:0] area_full;

	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [SCORE_W-1:0] best_score_q;

	logic             scan_v_s1, sup_v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             v_s2, v_s3, v_s4, v_s5;
	logic [IDX_W-1:0] idx_s2, idx_s3, idx_s4, idx_s5;
	logic [16:0]      iw_s2, ih_s2;
	logic signed [AREA_W-1:0] areab_s2, areab_s3;
	logic [33:0]      inter_s3, inter_s4;
	logic signed [35:0] uni_s4;
	logic signed [52:0] prod_s5;
	logic [49:0]      lhs_s5;
	logic             upos_s5;

	logic signed [15:0] ix1, ix2, iy1, iy2;
	logic signed [17:0] iw_raw, ih_raw;
	logic             sup_hit;

	// Unpack the incoming item and form its area
	always_comb begin
		new_box.x1    = in_data[15:0];
		new_box.y1    = in_data[31:16];
		new_box.x2    = in_data[47:32];
		new_box.y2    = in_data[63:48];
		new_box.score = in_data[79:64];
		new_box.label = LABEL_BITS'(in_data[86:80]);
		dx = {new_box.x2[15], new_box.x2[15], new_box.x2}
			- {new_box.x1[15], new_box.x1[15], new_box.x1} + 18'sd16;
		dy = {new_box.y2[15], new_box.y2[15], new_box.y2}
			- {new_box.y1[15], new_box.y1[15], new_box.y1} + 18'sd16;
		area_full = dx * dy;
		new_box.area = area_full[AREA_W-1:0];
	end

	assign wr_en   = cmd.load && in_has_box && (count_q < CNT_W'(MAX_BOXES));
	assign rd_en   = cmd.scan_rd || cmd.sup_rd || cmd.pick_rd;
	assign rd_addr = cmd.pick_rd ? best_idx_q : cmd.rd_idx;

	// Box memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IDX_W-1:0]] <= new_box;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Intersection of the picked box with the box just read
	always_comb begin
		ix1 = (a_q.x1 > rd_q.x1) ? a_q.x1 : rd_q.x1;
		iy1 = (a_q.y1 > rd_q.y1) ? a_q.y1 : rd_q.y1;
		ix2 = (a_q.x2 < rd_q.x2) ? a_q.x2 : rd_q.x2;
		iy2 = (a_q.y2 < rd_q.y2) ? a_q.y2 : rd_q.y2;
		iw_raw = {ix2[15], ix2[15], ix2} - {ix1[15], ix1[15], ix1} + 18'sd16;
		ih_raw = {iy2[15], iy2[15], iy2} - {iy1[15], iy1[15], iy1} + 18'sd16;
		sup_hit = sup_v_s1 && !gone_q[idx_s1] && (a_q.label == rd_q.label);
	end

	// Mark the entries loaded in this batch
	always_comb begin
		for (int k = 0; k < MAX_BOXES; k++) begin
			live_mask[k] = (CNT_W'(k) < count_q);
		end
	end

	// Control registers: threshold, fill count, overflow, flags, pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THR_RESET;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			gone_q       <= '0;
			best_found_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			sup_v_s1     <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.load && in_has_box) begin
				if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			scan_v_s1 <= cmd.scan_rd;
			sup_v_s1  <= cmd.sup_rd;
			v_s2      <= sup_hit;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			// track the best unsuppressed score, first arrival wins ties
			if (cmd.scan_start) begin
				best_found_q <= 1'b0;
			end else if (scan_v_s1 && !gone_q[idx_s1]
					&& (!best_found_q || rd_q.score > best_score_q)) begin
				best_found_q <= 1'b1;
			end
			if (cmd.take_pick) begin
				gone_q[best_idx_q] <= 1'b1;
			end
			if (v_s5 && upos_s5 && ($signed({4'b0, lhs_s5}) >= prod_s5)) begin
				gone_q[idx_s5] <= 1'b1;
			end
			if (cmd.clr_batch) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
				gone_q  <= '0;
			end
			if (cmd.emit || cmd.emit_empty) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
		if (scan_v_s1 && !gone_q[idx_s1] && (!best_found_q || rd_q.score > best_score_q)) begin
			best_idx_q   <= idx_s1;
			best_score_q <= rd_q.score;
		end
		if (cmd.take_pick) begin
			a_q <= rd_q;
		end
		// overlap pipeline: extents, intersection, union, scaled compare
		idx_s2   <= idx_s1;
		iw_s2    <= iw_raw[17] ? 17'd0 : iw_raw[16:0];
		ih_s2    <= ih_raw[17] ? 17'd0 : ih_raw[16:0];
		areab_s2 <= rd_q.area;
		idx_s3   <= idx_s2;
		inter_s3 <= 34'(iw_s2 * ih_s2);
		areab_s3 <= areab_s2;
		idx_s4   <= idx_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= 36'(a_q.area) + 36'(areab_s3) - $signed({2'b0, inter_s3});
		idx_s5   <= idx_s4;
		lhs_s5   <= {inter_s4, 16'd0};
		prod_s5  <= $signed({1'b0, thr_q}) * uni_s4;
		upos_s5  <= (uni_s4 > 36'sd0);
		// result register
		if (cmd.emit) begin
			m_tdata <= {1'b0, OUT_LABEL_W'(a_q.label), a_q.score,
				a_q.y2, a_q.x2, a_q.y1, a_q.x1};
			m_tuser <= {ovf_q, 1'b0};
			m_tlast <= ~sts.remaining;
		end else if (cmd.emit_empty) begin
			m_tdata <= '0;
			m_tuser <= {ovf_q, 1'b1};
			m_tlast <= 1'b1;
		end
	end

	assign sts.count     = count_q;
	assign sts.busy      = scan_v_s1 || sup_v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.remaining = |(~gone_q & live_mask);
	assign sts.out_full  = m_tvalid;
endmodule
`default_nettype wire

[rtl/core/cabs_ctrl.sv]
// Controller: sequences loading, best-score scans, suppression passes and
// result emission. Depends on cabs_pkg; commands cabs_dp.
`default_nettype none
module cabs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           in_last,
	input  wire cabs_pkg::sts_t sts,
	output cabs_pkg::cmd_t      cmd
);
	import cabs_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_SCAN, S_SCAN_WAIT, S_PICK, S_PICK_WAIT,
		S_SUP, S_SUP_WAIT, S_EMIT, S_EMPTY
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] j_q;
	logic             last_j;

	assign in_ready = (state_q == S_IDLE);
	assign last_j   = (j_q == sts.count - CNT_W'(1));

	// Decode commands from state
	always_comb begin
		cmd            = '0;
		cmd.rd_idx     = j_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE:      cmd.load = in_valid;
			S_START:     cmd.scan_start = (sts.count != '0);
			S_SCAN:      cmd.scan_rd = 1'b1;
			S_PICK:      cmd.pick_rd = 1'b1;
			S_PICK_WAIT: cmd.take_pick = 1'b1;
			S_SUP:       cmd.sup_rd = 1'b1;
			S_EMIT: begin
				cmd.emit      = !sts.out_full;
				cmd.clr_batch = !sts.out_full && !sts.remaining;
			end
			S_EMPTY: begin
				cmd.emit_empty = !sts.out_full;
				cmd.clr_batch  = !sts.out_full;
			end
			default: cmd = '0;
		endcase
	end

	// Advance state and the entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_last) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					j_q     <= '0;
					state_q <= (sts.count == '0) ? S_EMPTY : S_SCAN;
				end
				S_SCAN: begin
					if (last_j) begin
						state_q <= S_SCAN_WAIT;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				S_SCAN_WAIT: if (!sts.busy) state_q <= S_PICK;
				S_PICK:      state_q <= S_PICK_WAIT;
				S_PICK_WAIT: begin
					j_q     <= '0;
					state_q <= S_SUP;
				end
				S_SUP: begin
					if (last_j) begin
						state_q <= S_SUP_WAIT;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				S_SUP_WAIT:  if (!sts.busy) state_q <= S_EMIT;
				S_EMIT: begin
					if (!sts.out_full) begin
						state_q <= sts.remaining ? S_START : S_IDLE;
					end
				end
				S_EMPTY:     if (!sts.out_full) state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/core/class_aware_box_suppression_top.sv]
// Per-class greedy box suppression. Boxes load at one item per cycle while
// s_axis_tready is high; the item with tlast closes the batch and the block
// then drops ready until the last survivor has been handed to the output
// register. For each survivor of a batch, one pass over the box memory finds
// the highest unsuppressed score and a second pass runs the overlap test
// against every entry, both limited by the memory's single read port. An
// empty batch gives one result with tuser bit 0 set. Up to 64 boxes are kept.
// Files: cabs_pkg, cabs_ctrl, cabs_dp.
`default_nettype none
module class_aware_box_suppression_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,   // iou_threshold, Q0.16
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// left_edge, top_edge, right_edge, bottom_edge, confidence, class_label, pad
	input  wire logic [87:0] s_axis_tdata,
	input  wire logic        s_axis_tuser,  // has_box
	input  wire logic        s_axis_tlast,  // batch_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_left, out_top, out_right, out_bottom, out_score, out_label, pad
	output logic [87:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // batch_empty, overflowed
	output logic             m_axis_tlast   // is_last
);
	import cabs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence the batch
	cabs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_last  (s_axis_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store, test and emit boxes
	cabs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_axis_tdata),
		.in_has_box  (s_axis_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.m_tlast     (m_axis_tlast)
	);
endmodule
`default_nettype wire

[rtl/core/cabs_checker.sv]
// Port-level checks for the box suppression top level, bound to it below.
// Depends on class_aware_box_suppression_top_defines.svh.
`default_nettype none
`include "class_aware_box_suppression_top_defines.svh"
module cabs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [87:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);
	// hold a pending result
	`CABS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// close the input after a batch end
	`CABS_ASSERT_NEXT(a_stop_after_end, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
	// an empty batch result is the only and last item
	`CABS_ASSERT_SAME(a_empty_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	// an empty batch result carries no box
	`CABS_ASSERT_SAME(a_empty_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 88'd0)
endmodule

bind class_aware_box_suppression_top cabs_checker u_cabs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
